>>> hdl/lcdw_pkg.sv
package lcdw_pkg;

    localparam int MAX_DIGITS_DEF = 5;
    localparam int NUM_W          = 16;
    localparam int BITCNT_W       = $clog2(NUM_W);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Text row start addresses; rows 1 and 2 interleave in the display RAM
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'h90;
            2'd2:    base = 8'h88;
            2'd3:    base = 8'h98;
            default: base = 8'h80;
        endcase
        return base;
    endfunction

endpackage

>>> hdl/lcd_decimal_number_writer.sv
// Decimal number writer: one set-address command, then 0..MAX_DIGITS ASCII digits.
// Binary to BCD runs on one shift/add-3 unit, one input bit per cycle.
// The command byte is registered after the last conversion step, once the output is free.
// A new request is taken only in idle; o_stall is high until the last byte is registered.
// Reset (synchronous, active low) returns to idle and drops any pending output.
module lcd_decimal_number_writer #(
    parameter int MAX_DIGITS = lcdw_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_row,
    input  logic [2:0]  i_column,
    input  logic [15:0] i_number,
    input  logic [2:0]  i_digit_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_data,
    output logic [7:0]  o_write_byte,
    output logic        o_last
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [lcdw_pkg::NUM_W-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0]              r_bcd, n_bcd;
    logic [lcdw_pkg::BITCNT_W-1:0] r_bitcnt, n_bitcnt;
    logic [2:0]                    r_digits, n_digits;
    logic                          r_first, n_first;
    logic [7:0]                    r_addr, n_addr;
    logic                          r_ovalid, n_ovalid;
    logic                          r_is_data, n_is_data;
    logic [7:0]                    r_byte, n_byte;
    logic                          r_last, n_last;

    logic             in_xfer;
    logic             out_free;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       cur_digit;
    logic [2:0]       cnt_sat;

    assign o_stall      = (r_state != S_IDLE);
    assign in_xfer      = i_valid && !o_stall;
    assign out_free     = !r_ovalid || !i_stall;
    assign o_valid      = r_ovalid;
    assign o_is_data    = r_is_data;
    assign o_write_byte = r_byte;
    assign o_last       = r_last;

    assign cnt_sat = (i_digit_count > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : i_digit_count;

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_digits == 3'(i + 1)) begin
                cur_digit = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_bitcnt  = r_bitcnt;
        n_digits  = r_digits;
        n_first   = r_first;
        n_addr    = r_addr;
        n_ovalid  = r_ovalid && i_stall;
        n_is_data = r_is_data;
        n_byte    = r_byte;
        n_last    = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_bin    = i_number;
                    n_bcd    = '0;
                    n_bitcnt = '0;
                    n_digits = cnt_sat;
                    n_addr   = lcdw_pkg::row_base(i_row) + {5'd0, i_column};
                    n_state  = S_CONV;
                end
            end
            S_CONV: begin
                if (BCD_W > 1) begin
                    n_bcd = {bcd_adj[BCD_W-2:0], r_bin[lcdw_pkg::NUM_W-1]};
                end
                n_bin    = {r_bin[lcdw_pkg::NUM_W-2:0], 1'b0};
                n_bitcnt = r_bitcnt + 1'b1;
                if (r_bitcnt == lcdw_pkg::BITCNT_W'(lcdw_pkg::NUM_W - 1)) begin
                    n_first = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_first) begin
                        n_first   = 1'b0;
                        n_is_data = 1'b0;
                        n_byte    = r_addr;
                        n_last    = (r_digits == 3'd0);
                        if (r_digits == 3'd0) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_is_data = 1'b1;
                        n_byte    = lcdw_pkg::ASCII_ZERO + {4'd0, cur_digit};
                        n_last    = (r_digits == 3'd1);
                        n_digits  = r_digits - 3'd1;
                        if (r_digits == 3'd1) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_first  <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_first  <= n_first;
            r_bitcnt <= n_bitcnt;
        end
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_digits  <= n_digits;
        r_addr    <= n_addr;
        r_is_data <= n_is_data;
        r_byte    <= n_byte;
        r_last    <= n_last;
    end

`ifndef SYNTHESIS
    a_xfer_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CONV) && (r_bitcnt == '0))
        else $error("transfer did not start conversion");

    a_conv_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) && (r_bitcnt == lcdw_pkg::BITCNT_W'(lcdw_pkg::NUM_W - 1))
        |=> (r_state == S_EMIT) && r_first)
        else $error("conversion did not hand over to emit");

    a_digit_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_data |-> (o_write_byte >= lcdw_pkg::ASCII_ZERO)
                              && (o_write_byte <= lcdw_pkg::ASCII_NINE))
        else $error("data byte is not a decimal digit");

    a_digits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_digits <= 3'(MAX_DIGITS)))
        else $error("digit count out of range");
`endif

endmodule
